/* hdl/vss_pkg.sv */
// Shared types, constants and helper functions for the voice session sequencer.
package vss_pkg;

    localparam int TIMER_BITS = 16;
    localparam int LEVEL_BITS = 15;

    localparam int LEVEL_W  = 15;
    localparam int TICK_W   = 10;
    localparam int LIMIT_W  = 16;
    localparam int STATE_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int SUM_W = ((TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W) + 1;
    localparam int CMP_W = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [LEVEL_W-1:0] LEVEL_MASK = LEVEL_W'((64'd1 << LEVEL_BITS) - 64'd1);

    // Register reset values
    localparam logic [LEVEL_W-1:0] RST_THRESHOLD = 15'd200;
    localparam logic [TICK_W-1:0]  RST_TICK_MS   = 10'd50;
    localparam logic [LIMIT_W-1:0] RST_SILENCE   = 16'd1500;
    localparam logic [LIMIT_W-1:0] RST_LISTEN    = 16'd8000;
    localparam logic [LIMIT_W-1:0] RST_THINK     = 16'd5000;
    localparam logic [LIMIT_W-1:0] RST_SPEAK     = 16'd3000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_TICK_MS   = 3'd1,
        CFG_SILENCE   = 3'd2,
        CFG_LISTEN    = 3'd3,
        CFG_THINK     = 3'd4,
        CFG_SPEAK     = 3'd5
    } cfg_index_t;

    typedef enum logic [STATE_W-1:0] {
        ST_IDLE   = 3'd0,
        ST_LISTEN = 3'd1,
        ST_THINK  = 3'd2,
        ST_SPEAK  = 3'd3,
        ST_PROV   = 3'd4
    } session_state_t;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_REQUEST = 1'b1
    } op_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] speech_threshold;
        logic [TICK_W-1:0]  tick_ms;
        logic [LIMIT_W-1:0] silence_limit_ms;
        logic [LIMIT_W-1:0] listen_limit_ms;
        logic [LIMIT_W-1:0] think_ms;
        logic [LIMIT_W-1:0] speak_ms;
    } cfg_t;

    typedef struct packed {
        op_t                operation;
        logic [STATE_W-1:0] requested_state;
        logic [LEVEL_W-1:0] mic_level;
    } item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic                tone_active;
        rgb_t                led;
        logic                state_changed;
        logic [STATE_W-1:0]  current_state;
    } result_t;

    function automatic rgb_t led_color(input session_state_t s);
        rgb_t c;
        case (s)
            ST_IDLE:   c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
            ST_LISTEN: c = '{red: 8'd0,   green: 8'd60,  blue: 8'd255};
            ST_THINK:  c = '{red: 8'd200, green: 8'd0,   blue: 8'd255};
            ST_SPEAK:  c = '{red: 8'd0,   green: 8'd255, blue: 8'd80};
            ST_PROV:   c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
            default:   c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
        endcase
        return c;
    endfunction

    // Saturating timer advance
    function automatic logic [TIMER_BITS-1:0] sat_add(
        input logic [TIMER_BITS-1:0] t,
        input logic [TICK_W-1:0]     d
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(t) + SUM_W'(d);
        return (s > SUM_W'(TIMER_MAX)) ? TIMER_MAX : s[TIMER_BITS-1:0];
    endfunction

    function automatic logic reached(
        input logic [TIMER_BITS-1:0] t,
        input logic [LIMIT_W-1:0]    limit
    );
        return CMP_W'(t) >= CMP_W'(limit);
    endfunction

endpackage

/* hdl/voice_session_sequencer.sv */
// Top level of the voice session sequencer: input and result registers around the core.
//
//  channel  | direction | ports                                   | content
//  ---------+-----------+-----------------------------------------+---------------------------
//  s_       | in        | s_tvalid s_tready s_tdata s_tuser       | tick or state request word
//  m_       | out       | m_tvalid m_tready m_tdata               | one result word per input
//  cfg_     | in        | cfg_valid cfg_ready cfg_index cfg_data  | register write
//
// One word per cycle while m_tready is high; words go input register -> result register.
// Session state updates as a word leaves the input register, so back-to-back
// words see each other's effects. A stalled m_ side holds the result register
// and the input register; s_tready drops only when both are full.
// Synchronous active-low reset; config writes complete in the cycle presented.
module voice_session_sequencer
    import vss_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // requested_state[2:0], mic_level[17:3], zero pad
    input  logic                  s_tuser,   // operation

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // current_state[2:0], state_changed[3],
                                             // led_red[11:4], led_green[19:12],
                                             // led_blue[27:20], tone_active[28], zero pad

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    result_t core_result;
    logic    fire;

    assign cfg_ready = 1'b1;

    vss_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.operation       <= op_t'(s_tuser);
            in_item_reg.requested_state <= s_tdata[2:0];
            in_item_reg.mic_level       <= s_tdata[17:3];
        end
    end

    vss_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_reg.tone_active,
                       out_reg.led.blue,
                       out_reg.led.green,
                       out_reg.led.red,
                       out_reg.state_changed,
                       out_reg.current_state};

endmodule

/* hdl/vss_cfg_regs.sv */
// Configuration register file for the voice session sequencer.
module vss_cfg_regs
    import vss_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (cfg_index_t'(wr_index))
                CFG_THRESHOLD: cfg_next.speech_threshold = wr_data[LEVEL_W-1:0];
                CFG_TICK_MS:   cfg_next.tick_ms          = wr_data[TICK_W-1:0];
                CFG_SILENCE:   cfg_next.silence_limit_ms = wr_data[LIMIT_W-1:0];
                CFG_LISTEN:    cfg_next.listen_limit_ms  = wr_data[LIMIT_W-1:0];
                CFG_THINK:     cfg_next.think_ms         = wr_data[LIMIT_W-1:0];
                CFG_SPEAK:     cfg_next.speak_ms         = wr_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speech_threshold <= RST_THRESHOLD;
            cfg_reg.tick_ms          <= RST_TICK_MS;
            cfg_reg.silence_limit_ms <= RST_SILENCE;
            cfg_reg.listen_limit_ms  <= RST_LISTEN;
            cfg_reg.think_ms         <= RST_THINK;
            cfg_reg.speak_ms         <= RST_SPEAK;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/vss_core.sv */
// Session state, timers and per-word state update.
module vss_core
    import vss_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    session_state_t          mode_reg, mode_next;
    logic                    seen_reg, seen_next;
    logic                    run_reg, run_next;
    logic                    started_reg, started_next;
    logic [TIMER_BITS-1:0]   sil_reg, sil_next;
    logic [TIMER_BITS-1:0]   phase_reg, phase_next;

    logic                    enter_en;
    session_state_t          enter_state;
    logic [TIMER_BITS-1:0]   phase_sum;
    logic [TIMER_BITS-1:0]   sil_sum;
    logic                    level_hit;

    assign phase_sum = sat_add(phase_reg, cfg.tick_ms);
    assign sil_sum   = sat_add(sil_reg, cfg.tick_ms);
    assign level_hit = (item.mic_level & LEVEL_MASK) > (cfg.speech_threshold & LEVEL_MASK);

    // Next state
    always_comb begin
        mode_next    = mode_reg;
        seen_next    = seen_reg;
        run_next     = run_reg;
        started_next = started_reg;
        sil_next     = sil_reg;
        phase_next   = phase_reg;
        enter_en     = 1'b0;
        enter_state  = ST_IDLE;

        if (item.operation == OP_REQUEST) begin
            if (item.requested_state <= ST_PROV && item.requested_state != mode_reg) begin
                enter_en    = 1'b1;
                enter_state = session_state_t'(item.requested_state);
            end
        end else begin
            case (mode_reg)
                ST_LISTEN: begin
                    // first tick only arms the listen timer
                    started_next = 1'b1;
                    phase_next   = started_reg ? phase_sum : '0;
                    if (level_hit) begin
                        seen_next = 1'b1;
                        run_next  = 1'b0;
                        sil_next  = '0;
                    end else if (seen_reg) begin
                        if (!run_reg) begin
                            run_next = 1'b1;
                            sil_next = '0;
                        end else begin
                            sil_next = sil_sum;
                            if (reached(sil_sum, cfg.silence_limit_ms)) begin
                                enter_en    = 1'b1;
                                enter_state = ST_THINK;
                            end
                        end
                    end
                    if (!enter_en && !seen_next &&
                        reached(phase_next, cfg.listen_limit_ms)) begin
                        enter_en    = 1'b1;
                        enter_state = ST_IDLE;
                    end
                end
                ST_THINK: begin
                    phase_next = phase_sum;
                    if (reached(phase_sum, cfg.think_ms)) begin
                        enter_en    = 1'b1;
                        enter_state = ST_SPEAK;
                    end
                end
                ST_SPEAK: begin
                    phase_next = phase_sum;
                    if (reached(phase_sum, cfg.speak_ms)) begin
                        enter_en    = 1'b1;
                        enter_state = ST_IDLE;
                    end
                end
                default: ;
            endcase
        end

        // any change of state clears timers and flags
        if (enter_en) begin
            mode_next    = enter_state;
            seen_next    = 1'b0;
            run_next     = 1'b0;
            started_next = 1'b0;
            sil_next     = '0;
            phase_next   = '0;
        end
    end

    // Outputs
    always_comb begin
        result.current_state = mode_next;
        result.state_changed = enter_en;
        result.led           = led_color(mode_next);
        result.tone_active   = (mode_next == ST_SPEAK);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= ST_IDLE;
            seen_reg    <= 1'b0;
            run_reg     <= 1'b0;
            started_reg <= 1'b0;
            sil_reg     <= '0;
            phase_reg   <= '0;
        end else if (fire) begin
            mode_reg    <= mode_next;
            seen_reg    <= seen_next;
            run_reg     <= run_next;
            started_reg <= started_next;
            sil_reg     <= sil_next;
            phase_reg   <= phase_next;
        end
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the voice session sequencer: directed state and timing cases, then random sessions.
module tb;
    import vss_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int ACC_W        = TIMER_BITS + 1;
    localparam int LEVEL_TOP    = (1 << LEVEL_W) - 1;
    localparam int LIMIT_TOP    = (1 << LIMIT_W) - 1;
    localparam logic [STATE_W-1:0]   FIRST_BAD_REQ = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic               changed;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               tone;
    } session_out_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b1;
    logic [31:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predicted session state and register copy
    session_state_t        mode;
    logic                  speech_seen, silence_running, listen_started;
    logic [TIMER_BITS-1:0] silence_ms, phase_ms;
    cfg_t                  regs;

    session_out_t          pending_results[$];
    int unsigned           error_count = 0;
    int unsigned           cycle_count = 0;
    int unsigned           words_sent = 0;
    int unsigned           changes_seen = 0;
    int unsigned           settings_used = 0;
    int unsigned           burst_left = 0;
    int unsigned           rx_tick = 0;
    int unsigned           rx_style = 0;
    int unsigned           state_words[5] = '{default: 0};

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    voice_session_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------- session predictor ----------------

    function automatic logic [TIMER_BITS-1:0] timer_step(input logic [TIMER_BITS-1:0] t);
        logic [ACC_W-1:0] sum;
        sum = ACC_W'(t) + ACC_W'(regs.tick_ms);
        return sum[TIMER_BITS] ? '1 : sum[TIMER_BITS-1:0];
    endfunction

    function automatic void enter_state(input session_state_t s);
        mode            = s;
        speech_seen     = 1'b0;
        silence_running = 1'b0;
        listen_started  = 1'b0;
        silence_ms      = '0;
        phase_ms        = '0;
    endfunction

    function automatic void reset_model();
        regs.speech_threshold = RST_THRESHOLD;
        regs.tick_ms          = RST_TICK_MS;
        regs.silence_limit_ms = RST_SILENCE;
        regs.listen_limit_ms  = RST_LISTEN;
        regs.think_ms         = RST_THINK;
        regs.speak_ms         = RST_SPEAK;
        enter_state(ST_IDLE);
    endfunction

    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_THRESHOLD: regs.speech_threshold = data[LEVEL_W-1:0];
            CFG_TICK_MS:   regs.tick_ms          = data[TICK_W-1:0];
            CFG_SILENCE:   regs.silence_limit_ms = data[LIMIT_W-1:0];
            CFG_LISTEN:    regs.listen_limit_ms  = data[LIMIT_W-1:0];
            CFG_THINK:     regs.think_ms         = data[LIMIT_W-1:0];
            CFG_SPEAK:     regs.speak_ms         = data[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [23:0] palette(input session_state_t s);
        case (s)
            ST_LISTEN: return {8'd0,   8'd60,  8'd255};
            ST_THINK:  return {8'd200, 8'd0,   8'd255};
            ST_SPEAK:  return {8'd0,   8'd255, 8'd80};
            ST_PROV:   return {8'd255, 8'd255, 8'd0};
            default:   return '0;
        endcase
    endfunction

    // one listening tick; returns 1 when it ends the listening phase
    function automatic logic listen_tick(input logic [LEVEL_W-1:0] lvl);
        if (!listen_started) begin
            listen_started = 1'b1;
            phase_ms       = '0;
        end else begin
            phase_ms = timer_step(phase_ms);
        end
        if (lvl > regs.speech_threshold) begin
            speech_seen     = 1'b1;
            silence_running = 1'b0;
            silence_ms      = '0;
        end else if (speech_seen) begin
            if (!silence_running) begin
                silence_running = 1'b1;
                silence_ms      = '0;
            end else begin
                silence_ms = timer_step(silence_ms);
                if (silence_ms >= regs.silence_limit_ms) begin
                    enter_state(ST_THINK);
                    return 1'b1;
                end
            end
        end
        if (!speech_seen && phase_ms >= regs.listen_limit_ms) begin
            enter_state(ST_IDLE);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic session_out_t predict_word(input op_t op,
                                                  input logic [STATE_W-1:0] req,
                                                  input logic [LEVEL_W-1:0] lvl);
        session_out_t r;
        logic         changed;
        changed = 1'b0;
        if (op == OP_REQUEST) begin
            if (req <= 3'(ST_PROV) && req != mode) begin
                enter_state(session_state_t'(req));
                changed = 1'b1;
            end
        end else begin
            case (mode)
                ST_LISTEN: changed = listen_tick(lvl);
                ST_THINK: begin
                    phase_ms = timer_step(phase_ms);
                    if (phase_ms >= regs.think_ms) begin
                        enter_state(ST_SPEAK);
                        changed = 1'b1;
                    end
                end
                ST_SPEAK: begin
                    phase_ms = timer_step(phase_ms);
                    if (phase_ms >= regs.speak_ms) begin
                        enter_state(ST_IDLE);
                        changed = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.state = mode;
        r.changed = changed;
        {r.red, r.green, r.blue} = palette(mode);
        r.tone = (mode == ST_SPEAK);
        return r;
    endfunction

    // ---------------- drivers ----------------

    task automatic send_word(input op_t op, input logic [STATE_W-1:0] req,
                             input logic [LEVEL_W-1:0] lvl);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, lvl, req};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_word(op, req, lvl));
        words_sent++;
        burst_left--;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        store_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] thr, tick, sil, lis, thk, spk);
        wait_drained();
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_TICK_MS, tick);
        write_reg(CFG_SILENCE, sil);
        write_reg(CFG_LISTEN, lis);
        write_reg(CFG_THINK, thk);
        write_reg(CFG_SPEAK, spk);
        settings_used++;
    endtask

    // receiver: own stall pattern, style changes every so often
    always @(negedge aclk) begin
        rx_tick++;
        if (rx_tick % 97 == 0) rx_style = $urandom_range(0, 3);
        case (rx_style)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_tick % 6 == 0);
            default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // ---------------- result checking ----------------

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        session_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (m_tdata[3]) changes_seen++;
            if (m_tdata[2:0] <= 3'(ST_PROV)) state_words[m_tdata[2:0]]++;
            if (pending_results.size() == 0) begin
                $error("result word 0x%08h with no word outstanding", m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("current_state", want.state,   m_tdata[2:0]);
                check_field("state_changed", want.changed, m_tdata[3]);
                check_field("led_red",       want.red,     m_tdata[11:4]);
                check_field("led_green",     want.green,   m_tdata[19:12]);
                check_field("led_blue",      want.blue,    m_tdata[27:20]);
                check_field("tone_active",   want.tone,    m_tdata[28]);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic logic [LEVEL_W-1:0] pick_level(input bit talking);
        int unsigned thr;
        thr = regs.speech_threshold;
        if ($urandom_range(0, 7) == 0) return LEVEL_W'($urandom_range(0, LEVEL_TOP));
        if (talking && thr < LEVEL_TOP)
            return ($urandom_range(0, 3) == 0) ? LEVEL_W'(thr + 1)
                                               : LEVEL_W'($urandom_range(thr + 1, LEVEL_TOP));
        return ($urandom_range(0, 3) == 0) ? LEVEL_W'(thr) : LEVEL_W'($urandom_range(0, thr));
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit(input int unsigned tick);
        int unsigned span;
        if ($urandom_range(0, 9) == 0) return LIMIT_W'($urandom_range(0, LIMIT_TOP));
        span = tick * $urandom_range(0, 10);
        return (span > LIMIT_TOP) ? '1 : LIMIT_W'(span);
    endfunction

    // mostly well-formed sessions: idle -> listening, then ticks with speech bursts
    task automatic run_session(input int unsigned quota, input int unsigned req_odds);
        int unsigned        effective;
        bit                 talking;
        op_t                op;
        logic [STATE_W-1:0] req;
        logic [LEVEL_W-1:0] lvl;
        session_state_t     prior;
        effective = 0;
        talking = 1'b0;
        while (effective < quota) begin
            prior = mode;
            req = STATE_W'($urandom_range(0, 7));
            lvl = LEVEL_W'($urandom_range(0, LEVEL_TOP));
            if (mode == ST_IDLE || mode == ST_PROV) begin
                op = ($urandom_range(0, 4) == 0) ? OP_TICK : OP_REQUEST;
                if ($urandom_range(0, 3) != 0) req = ST_LISTEN;
                talking = 1'($urandom_range(0, 1));
            end else if ($urandom_range(1, req_odds) == 1) begin
                op = OP_REQUEST;
            end else begin
                op = OP_TICK;
                if ($urandom_range(0, 5) == 0) talking = !talking;
                lvl = pick_level(talking);
            end
            send_word(op, req, lvl);
            // idle and provisioning ticks and ignored requests do not count
            if (op == OP_TICK ? (prior != ST_IDLE && prior != ST_PROV) : (mode != prior))
                effective++;
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_state_requests();
        send_word(OP_TICK, ST_THINK, '1);          // tick while idle does nothing
        send_word(OP_REQUEST, ST_PROV, '0);
        send_word(OP_TICK, ST_IDLE, '1);
        send_word(OP_REQUEST, ST_PROV, '1);         // same state, ignored
        for (int c = FIRST_BAD_REQ; c < (1 << STATE_W); c++)
            send_word(OP_REQUEST, STATE_W'(c), '0);
        send_word(OP_REQUEST, ST_IDLE, '0);
        send_word(OP_REQUEST, ST_LISTEN, '0);
        send_word(OP_REQUEST, ST_THINK, '0);
        send_word(OP_REQUEST, ST_SPEAK, '0);
        send_word(OP_REQUEST, ST_LISTEN, '0);
        send_word(OP_TICK, ST_IDLE, '0);
        send_word(OP_REQUEST, ST_LISTEN, '0);       // same state keeps timers
        send_word(OP_TICK, ST_IDLE, '0);
        send_word(OP_REQUEST, ST_IDLE, '0);
    endtask

    task automatic test_listen_timing();
        apply_settings(16'd100, 16'd50, 16'd100, 16'd100, 16'd0, 16'd0);
        send_word(OP_REQUEST, ST_LISTEN, '0);
        send_word(OP_TICK, ST_IDLE, 15'd100);       // level equal to threshold is quiet
        send_word(OP_TICK, ST_IDLE, 15'd101);       // speech
        send_word(OP_TICK, ST_IDLE, '0);            // silence timer starts
        send_word(OP_TICK, ST_IDLE, '0);
        send_word(OP_TICK, ST_IDLE, '0);            // silence limit -> thinking
        send_word(OP_TICK, ST_IDLE, '1);            // zero think time -> speaking
        send_word(OP_TICK, ST_IDLE, '0);            // zero speak time -> idle
        send_word(OP_REQUEST, ST_LISTEN, '0);
        send_word(OP_TICK, ST_IDLE, '0);
        send_word(OP_TICK, ST_IDLE, '0);
        send_word(OP_TICK, ST_IDLE, '0);            // listen limit, no speech -> idle
    endtask

    task automatic test_register_edges();
        wait_drained();
        write_reg(CFG_SPARE_LO, 16'hFFFF);          // unknown indexes change nothing
        write_reg(CFG_SPARE_HI, 16'h0001);
        // oversized values get masked; listen timer runs into saturation
        apply_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_session(80, 300);
        // zero tick: time stands still, every limit is zero
        apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_session(40, 20);
        // saturated thinking and speaking timers
        apply_settings(16'd0, 16'd1000, 16'd3000, 16'd0, 16'hFFFF, 16'hFFFF);
        run_session(200, 300);
    endtask

    task automatic test_random_sessions();
        int unsigned tick;
        apply_settings(16'd200, 16'd1000, 16'd1500, 16'd8000, 16'd5000, 16'd3000);
        run_session(56, 20);
        repeat (4) begin
            tick = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1000) : $urandom_range(1, 100);
            apply_settings(CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, LEVEL_TOP)
                                                                   : $urandom_range(0, 1000)),
                           CFG_DATA_W'(tick), pick_limit(tick), pick_limit(tick),
                           pick_limit(tick), pick_limit(tick));
            run_session(56, 20);
        end
    endtask

    initial begin
        reset_model();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_state_requests();
        test_listen_timing();
        test_register_edges();
        test_random_sessions();

        wait_drained();
        $display("Sent %0d words under %0d register settings; %0d state changes observed.",
                 words_sent, settings_used + 1, changes_seen);
        $display("Words per state: idle %0d listen %0d think %0d speak %0d provision %0d",
                 state_words[ST_IDLE], state_words[ST_LISTEN], state_words[ST_THINK],
                 state_words[ST_SPEAK], state_words[ST_PROV]);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/vss_pkg.sv
hdl/vss_cfg_regs.sv
hdl/vss_core.sv
hdl/voice_session_sequencer.sv
dv/tb.sv
